[sv/mvd_pkg.sv]
// Package: shared constants, types and helpers for the masked volume downsampler.
package mvd_pkg;

  localparam int MaxWidthDefault    = 512;
  localparam int MaxHeightDefault   = 512;
  localparam int FractionBitsDefault = 8;

  localparam int MaskW  = 8;
  localparam int DispW  = 24;
  localparam int SumW   = 27;
  localparam int CountW = 4;
  localparam int DimW   = 10;
  localparam int DepthW = 16;

  localparam int RegWidth  = 0;
  localparam int RegHeight = 1;
  localparam int RegDepth  = 2;
  localparam int AddrW     = 4;

  // Reciprocal of 2*c, c = 1..8, scaled by 2^RecipShift and rounded up;
  // the shift is wide enough that the floor of |sum|*recip is exact.
  localparam int RecipShift = 31;
  localparam int RecipW     = 31;

  typedef struct packed {
    logic start;     // first voxel of a block: clear accumulator entry
    logic emit;      // block completes on this voxel
    logic done;      // final voxel of the volume
  } mvd_cmd_t;

  typedef struct packed {
    logic busy;      // divide in flight or result not yet taken
  } mvd_stat_t;

  function automatic logic [RecipW-1:0] recip_of(input logic [CountW-1:0] c);
    logic [RecipW-1:0] r;
    case (c)
      4'd1: r = 31'd1073741824;  // 2^31/2
      4'd2: r = 31'd536870912;
      4'd3: r = 31'd357913942;
      4'd4: r = 31'd268435456;
      4'd5: r = 31'd214748365;
      4'd6: r = 31'd178956971;
      4'd7: r = 31'd153391690;
      4'd8: r = 31'd134217728;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/mvd_stream_if.sv]
// Interfaces: voxel input and block output channels.
interface mvd_in_if;
  logic valid;
  logic ready;
  logic [mvd_pkg::MaskW-1:0] mask_value;
  logic signed [mvd_pkg::DispW-1:0] disp_x;
  logic signed [mvd_pkg::DispW-1:0] disp_y;
  logic signed [mvd_pkg::DispW-1:0] disp_z;
  modport source (output valid, mask_value, disp_x, disp_y, disp_z, input ready);
  modport sink (input valid, mask_value, disp_x, disp_y, disp_z, output ready);
endinterface

interface mvd_out_if;
  logic valid;
  logic ready;
  logic [mvd_pkg::MaskW-1:0] mask_max;
  logic signed [mvd_pkg::DispW-1:0] mean_x;
  logic signed [mvd_pkg::DispW-1:0] mean_y;
  logic signed [mvd_pkg::DispW-1:0] mean_z;
  logic [mvd_pkg::CountW-1:0] masked_count;
  logic volume_done;
  modport source (output valid, mask_max, mean_x, mean_y, mean_z, masked_count,
                  volume_done, input ready);
  modport sink (input valid, mask_max, mean_x, mean_y, mean_z, masked_count,
                volume_done, output ready);
endinterface

[sv/masked_volume_downsample_by_two_unit.sv]
// Top level: 2x2x2 masked mean downsampler with APB configuration.
// Takes one voxel a cycle inside a block; a voxel that completes a block
// stalls input while the accumulator entry is written back, the reciprocal
// multiply runs and the result is registered into the output register;
// input also waits while that result is not taken.
// The accumulator plane is a single-port-write memory of
// ((MAX_WIDTH+1)/2)*((MAX_HEIGHT+1)/2) entries; any write to the width,
// height or depth register restarts the volume at the origin.
module masked_volume_downsample_by_two_unit #(
  parameter int MAX_WIDTH     = mvd_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT    = mvd_pkg::MaxHeightDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mvd_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  mvd_in_if.sink    in_ch,
  mvd_out_if.source out_ch
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [mvd_pkg::DimW-1:0]   volume_width, volume_height;
  logic [mvd_pkg::DepthW-1:0] volume_depth;
  logic wr_en, restart, accept;
  mvd_pkg::mvd_cmd_t  cmd;
  mvd_pkg::mvd_stat_t stat;
  logic [XW-1:0] col;
  logic [YW-1:0] row;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign restart = wr_en && (paddr[mvd_pkg::AddrW-1:2] <= 2'(mvd_pkg::RegDepth));

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_width  <= mvd_pkg::DimW'(1);
      volume_height <= mvd_pkg::DimW'(1);
      volume_depth  <= mvd_pkg::DepthW'(1);
    end else if (restart) begin
      case (32'(paddr[mvd_pkg::AddrW-1:2]))
        mvd_pkg::RegWidth:  volume_width  <= pwdata[mvd_pkg::DimW-1:0];
        mvd_pkg::RegHeight: volume_height <= pwdata[mvd_pkg::DimW-1:0];
        mvd_pkg::RegDepth:  volume_depth  <= pwdata[mvd_pkg::DepthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (32'(paddr[mvd_pkg::AddrW-1:2]))
      mvd_pkg::RegWidth:  prdata = 32'(volume_width);
      mvd_pkg::RegHeight: prdata = 32'(volume_height);
      mvd_pkg::RegDepth:  prdata = 32'(volume_depth);
      default: prdata = '0;
    endcase
  end

  mvd_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk, .rst, .restart, .volume_width, .volume_height, .volume_depth,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .accept, .cmd, .col, .row, .stat
  );

  mvd_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk, .rst, .accept, .cmd, .col, .row, .stat, .in_ch, .out_ch
  );

endmodule

[sv/mvd_ctrl.sv]
// Controller: voxel position tracking, handshake sequencing, block commands.
module mvd_ctrl #(
  parameter int MAX_WIDTH  = mvd_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = mvd_pkg::MaxHeightDefault,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic clk,
  input  logic rst,
  input  logic restart,
  input  logic [mvd_pkg::DimW-1:0]   volume_width,
  input  logic [mvd_pkg::DimW-1:0]   volume_height,
  input  logic [mvd_pkg::DepthW-1:0] volume_depth,
  input  logic in_valid,
  output logic in_ready,
  output logic accept,
  output mvd_pkg::mvd_cmd_t cmd,
  output logic [XW-1:0] col,
  output logic [YW-1:0] row,
  input  mvd_pkg::mvd_stat_t stat
);

  typedef enum logic [0:0] {IDLE, WAIT} state_t;
  state_t state;

  logic [XW-1:0] pos_x;
  logic [YW-1:0] pos_y;
  logic [mvd_pkg::DepthW-1:0] pos_z;
  logic [XW:0] w_eff;
  logic [YW:0] h_eff;
  logic [mvd_pkg::DepthW-1:0] d_eff;
  logic last_x, last_y, last_z;

  // width and height saturate to the maxima, zero means one in every dimension
  always_comb begin
    if (volume_width == '0) w_eff = (XW+1)'(1);
    else if (32'(volume_width) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
    else w_eff = (XW+1)'(volume_width);
    if (volume_height == '0) h_eff = (YW+1)'(1);
    else if (32'(volume_height) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
    else h_eff = (YW+1)'(volume_height);
    d_eff = (volume_depth == '0) ? mvd_pkg::DepthW'(1) : volume_depth;
  end

  assign last_x = ({1'b0, pos_x} == w_eff - (XW+1)'(1));
  assign last_y = ({1'b0, pos_y} == h_eff - (YW+1)'(1));
  assign last_z = (pos_z == d_eff - mvd_pkg::DepthW'(1));

  assign in_ready = (state == IDLE) && !stat.busy;
  assign accept   = in_valid && in_ready;
  assign col = pos_x;
  assign row = pos_y;
  assign cmd.start = !(pos_x[0] | pos_y[0] | pos_z[0]);
  assign cmd.emit  = (pos_x[0] || last_x) && (pos_y[0] || last_y) && (pos_z[0] || last_z);
  assign cmd.done  = last_x && last_y && last_z;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            if (cmd.emit) state <= WAIT;
            if (last_x) begin
              pos_x <= '0;
              if (last_y) begin
                pos_y <= '0;
                pos_z <= last_z ? '0 : pos_z + 1'b1;
              end else begin
                pos_y <= pos_y + 1'b1;
              end
            end else begin
              pos_x <= pos_x + 1'b1;
            end
          end
        end
        WAIT: state <= IDLE;   // hold input during the plane write-back
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[sv/mvd_datapath.sv]
// Datapath: accumulator planes, mean computation and output register.
module mvd_datapath #(
  parameter int MAX_WIDTH     = mvd_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT    = mvd_pkg::MaxHeightDefault,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  mvd_pkg::mvd_cmd_t cmd,
  input  logic [XW-1:0] col,
  input  logic [YW-1:0] row,
  output mvd_pkg::mvd_stat_t stat,
  mvd_in_if.sink  in_ch,
  mvd_out_if.source out_ch
);

  localparam int HalfW = (MAX_WIDTH + 1) / 2;
  localparam int HalfH = (MAX_HEIGHT + 1) / 2;
  localparam int Depth = HalfW * HalfH;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int EW = 3 * mvd_pkg::SumW + mvd_pkg::CountW + mvd_pkg::MaskW;
  localparam int PW = mvd_pkg::SumW + mvd_pkg::RecipW;

  typedef struct packed {
    logic signed [mvd_pkg::SumW-1:0] sx;
    logic signed [mvd_pkg::SumW-1:0] sy;
    logic signed [mvd_pkg::SumW-1:0] sz;
    logic [mvd_pkg::CountW-1:0] cnt;
    logic [mvd_pkg::MaskW-1:0] mmax;
  } entry_t;

  logic [EW-1:0] plane [Depth];
  logic [AW-1:0] addr;
  entry_t rd, cur, nxt;
  logic [AW-1:0] wa_q;
  logic wr_q, start_q, emit_q, done_q;
  logic [mvd_pkg::MaskW-1:0] m_q;
  logic signed [mvd_pkg::DispW-1:0] dx_q, dy_q, dz_q;
  logic div_v;
  entry_t dv;
  logic dv_done;
  logic signed [PW-1:0] px, py, pz;

  assign addr = AW'(32'(row >> 1) * HalfW + 32'(col >> 1));

  // stage 1: capture voxel and read entry; bypass the write-back of the
  // previous voxel when it hits the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q <= 1'b0;
    end else begin
      wr_q <= accept;
    end
    if (accept) begin
      rd      <= (wr_q && (wa_q == addr)) ? nxt : entry_t'(plane[addr]);
      wa_q    <= addr;
      start_q <= cmd.start;
      emit_q  <= cmd.emit;
      done_q  <= cmd.done;
      m_q     <= in_ch.mask_value;
      dx_q    <= in_ch.disp_x;
      dy_q    <= in_ch.disp_y;
      dz_q    <= in_ch.disp_z;
    end
  end

  // stage 2: update and write back
  always_comb begin
    cur = start_q ? entry_t'('0) : rd;
    nxt = cur;
    if (m_q > cur.mmax) nxt.mmax = m_q;
    if (m_q != '0) begin
      nxt.sx  = cur.sx + mvd_pkg::SumW'(dx_q);
      nxt.sy  = cur.sy + mvd_pkg::SumW'(dy_q);
      nxt.sz  = cur.sz + mvd_pkg::SumW'(dz_q);
      nxt.cnt = cur.cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_q) plane[wa_q] <= EW'(nxt);
  end

  // stage 3: reciprocal multiply, then stage 4 truncate toward zero
  function automatic logic signed [mvd_pkg::DispW-1:0] fin(
      input logic signed [PW-1:0] p, input logic neg);
    logic signed [PW-1:0] a;
    a = neg ? p + PW'((64'd1 << mvd_pkg::RecipShift) - 64'd1) : p;
    return mvd_pkg::DispW'(a >>> mvd_pkg::RecipShift);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      div_v <= wr_q && emit_q;
      if (div_v) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
    if (wr_q && emit_q) begin
      dv <= nxt;
      dv_done <= done_q;
      px <= PW'(nxt.sx) * $signed({1'b0, mvd_pkg::recip_of(nxt.cnt)});
      py <= PW'(nxt.sy) * $signed({1'b0, mvd_pkg::recip_of(nxt.cnt)});
      pz <= PW'(nxt.sz) * $signed({1'b0, mvd_pkg::recip_of(nxt.cnt)});
    end
    if (div_v) begin
      out_ch.mask_max     <= dv.mmax;
      out_ch.masked_count <= dv.cnt;
      out_ch.volume_done  <= dv_done;
      out_ch.mean_x <= fin(px, dv.sx[mvd_pkg::SumW-1]);
      out_ch.mean_y <= fin(py, dv.sy[mvd_pkg::SumW-1]);
      out_ch.mean_z <= fin(pz, dv.sz[mvd_pkg::SumW-1]);
    end
  end

  // hold input while a block result is in flight or undelivered
  assign stat.busy = (wr_q && emit_q) || div_v || (out_ch.valid && !out_ch.ready);

endmodule

[sv/mvd_checker.sv]
// Checker: port-level properties of the downsampler, bound to the top level.
module mvd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [3:0] masked_count,
  input logic [23:0] mean_x,
  input logic pready
);
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> masked_count <= 4'd8) else $error("count out of range");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && masked_count == 4'd0 |-> mean_x == '0) else $error("empty mean");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind masked_volume_downsample_by_two_unit mvd_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .masked_count(out_ch.masked_count), .mean_x(out_ch.mean_x), .pready
);

[dv/mvd_checker.sv]
// Checker: watches both channels, predicts block outputs and compares them.
`timescale 1ns / 100ps
module tb_mvd_checker (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mvd_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic pready,
  mvd_in_if.sink   in_mon,
  mvd_out_if.sink  out_mon,
  output int       fail_count,
  output int       pending
);

  localparam int HalfW = (mvd_pkg::MaxWidthDefault + 1) / 2;
  localparam int HalfH = (mvd_pkg::MaxHeightDefault + 1) / 2;

  typedef struct packed {
    logic [mvd_pkg::MaskW-1:0] mask_max;
    logic [mvd_pkg::DispW-1:0] mean_x;
    logic [mvd_pkg::DispW-1:0] mean_y;
    logic [mvd_pkg::DispW-1:0] mean_z;
    logic [mvd_pkg::CountW-1:0] cnt;
    logic done;
  } block_t;

  block_t block_q[$];
  logic signed [mvd_pkg::SumW-1:0] acc_x[HalfW*HalfH];
  logic signed [mvd_pkg::SumW-1:0] acc_y[HalfW*HalfH];
  logic signed [mvd_pkg::SumW-1:0] acc_z[HalfW*HalfH];
  logic [mvd_pkg::CountW-1:0] acc_n[HalfW*HalfH];
  logic [mvd_pkg::MaskW-1:0] acc_m[HalfW*HalfH];
  int px, py, pz;
  logic [mvd_pkg::DimW-1:0] vw, vh;
  logic [mvd_pkg::DepthW-1:0] vd;

  assign pending = block_q.size();

  function automatic logic [mvd_pkg::DispW-1:0] half_mean(
      input logic signed [mvd_pkg::SumW-1:0] s, input logic [mvd_pkg::CountW-1:0] c);
    longint q;
    if (c == 0) return '0;
    q = longint'(s) / longint'(2 * c);
    return q[mvd_pkg::DispW-1:0];
  endfunction

  function automatic int clip_dim(input int v, input int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  task automatic take_voxel(input logic [mvd_pkg::MaskW-1:0] m,
                            input logic signed [mvd_pkg::DispW-1:0] dx,
                            input logic signed [mvd_pkg::DispW-1:0] dy,
                            input logic signed [mvd_pkg::DispW-1:0] dz);
    int w, h, d, idx;
    logic lx, ly, lz;
    block_t b;
    w = clip_dim(vw, mvd_pkg::MaxWidthDefault);
    h = clip_dim(vh, mvd_pkg::MaxHeightDefault);
    d = clip_dim(vd, 65535);
    if (px >= w) px = 0;
    if (py >= h) py = 0;
    if (pz >= d) pz = 0;
    idx = (py >> 1) * HalfW + (px >> 1);
    if (((px | py | pz) & 1) == 0) begin
      acc_x[idx] = 0; acc_y[idx] = 0; acc_z[idx] = 0;
      acc_n[idx] = 0; acc_m[idx] = 0;
    end
    if (m > acc_m[idx]) acc_m[idx] = m;
    if (m != 0) begin
      acc_x[idx] = acc_x[idx] + dx;
      acc_y[idx] = acc_y[idx] + dy;
      acc_z[idx] = acc_z[idx] + dz;
      acc_n[idx] = acc_n[idx] + 1'b1;
    end
    lx = (px == w - 1);
    ly = (py == h - 1);
    lz = (pz == d - 1);
    if ((px[0] || lx) && (py[0] || ly) && (pz[0] || lz)) begin
      b.mask_max = acc_m[idx];
      b.mean_x = half_mean(acc_x[idx], acc_n[idx]);
      b.mean_y = half_mean(acc_y[idx], acc_n[idx]);
      b.mean_z = half_mean(acc_z[idx], acc_n[idx]);
      b.cnt = acc_n[idx];
      b.done = lx && ly && lz;
      block_q.push_back(b);
    end
    px++;
    if (px >= w) begin
      px = 0; py++;
      if (py >= h) begin
        py = 0; pz++;
        if (pz >= d) pz = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    block_t e;
    if (rst) begin
      px = 0; py = 0; pz = 0;
      vw = 1; vh = 1; vd = 1;
      fail_count = 0;
      block_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr) / 4)
          mvd_pkg::RegWidth: vw = pwdata[mvd_pkg::DimW-1:0];
          mvd_pkg::RegHeight: vh = pwdata[mvd_pkg::DimW-1:0];
          mvd_pkg::RegDepth: vd = pwdata[mvd_pkg::DepthW-1:0];
          default: ;
        endcase
        if (int'(paddr) / 4 <= mvd_pkg::RegDepth) begin
          px = 0; py = 0; pz = 0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (block_q.size() == 0) begin
          $error("unexpected output transaction");
          fail_count++;
        end else begin
          e = block_q.pop_front();
          if (out_mon.mask_max !== e.mask_max) begin
            $error("mask_max exp %0h got %0h", e.mask_max, out_mon.mask_max); fail_count++;
          end
          if (out_mon.mean_x !== e.mean_x) begin
            $error("mean_x exp %0h got %0h", e.mean_x, out_mon.mean_x); fail_count++;
          end
          if (out_mon.mean_y !== e.mean_y) begin
            $error("mean_y exp %0h got %0h", e.mean_y, out_mon.mean_y); fail_count++;
          end
          if (out_mon.mean_z !== e.mean_z) begin
            $error("mean_z exp %0h got %0h", e.mean_z, out_mon.mean_z); fail_count++;
          end
          if (out_mon.masked_count !== e.cnt) begin
            $error("masked_count exp %0d got %0d", e.cnt, out_mon.masked_count);
            fail_count++;
          end
          if (out_mon.volume_done !== e.done) begin
            $error("volume_done exp %0b got %0b", e.done, out_mon.volume_done);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        take_voxel(in_mon.mask_value, in_mon.disp_x, in_mon.disp_y, in_mon.disp_z);
    end
  end
endmodule

[dv/tb_masked_volume_downsample_by_two_unit.sv]
// Testbench top: drives voxels and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb_masked_volume_downsample_by_two_unit;

  // first index past the register list
  localparam int RegUnused = mvd_pkg::RegDepth + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [mvd_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int voxels_sent;

  mvd_in_if in_ch();
  mvd_out_if out_ch();

  masked_volume_downsample_by_two_unit i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  tb_mvd_checker i_chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_mon(in_ch.sink), .out_mon(out_ch.sink), .fail_count, .pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mask_value = '0;
    in_ch.disp_x = '0;
    in_ch.disp_y = '0;
    in_ch.disp_z = '0;
    out_ch.ready = 1'b0;
  end

  // output side stall, drawn per transaction
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  task automatic reg_write(input int idx, input int val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= mvd_pkg::AddrW'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_dims(input int w, input int h, input int d);
    wait_idle();
    reg_write(mvd_pkg::RegWidth, w);
    reg_write(mvd_pkg::RegHeight, h);
    reg_write(mvd_pkg::RegDepth, d);
  endtask

  task automatic send_voxel(input logic [7:0] m, input logic [23:0] x,
                            input logic [23:0] y, input logic [23:0] z, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mask_value <= m;
    in_ch.disp_x <= x;
    in_ch.disp_y <= y;
    in_ch.disp_z <= z;
    @(posedge clk iff in_ch.ready);
    voxels_sent++;
  endtask

  task automatic send_random(input int n, input bit calm);
    logic [7:0] m;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: m = 8'd0;
        1: m = 8'hff;
        default: m = 8'($urandom_range(0, 255));
      endcase
      send_voxel(m, 24'($urandom), 24'($urandom), 24'($urandom), calm);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    bit calm;
    voxels_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset dims 1x1x1: every voxel a block
    send_voxel(8'd0, 24'h7fffff, 24'h800000, 24'h000001, 1'b0);
    send_voxel(8'd1, 24'h7fffff, 24'h800000, 24'hffffff, 1'b0);
    send_voxel(8'hff, 24'h800000, 24'h7fffff, 24'h000003, 1'b0);
    in_ch.valid <= 1'b0;
    // all masked, extreme vectors, 2x2x2
    set_dims(2, 2, 2);
    repeat (8) send_voxel(8'hff, 24'h7fffff, 24'h800000, 24'hfffffd, 1'b0);
    repeat (8) send_voxel(8'h80, 24'h800000, 24'h7fffff, 24'h000005, 1'b1);
    in_ch.valid <= 1'b0;
    // odd sides and zero registers
    set_dims(3, 1, 3);
    send_random(9, 1'b0);
    set_dims(0, 0, 0);
    send_random(2, 1'b0);
    while (voxels_sent < 1200) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: set_dims($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
        1: set_dims($urandom_range(1, 9), $urandom_range(1, 5), $urandom_range(1, 3));
        2: set_dims(512 + $urandom_range(0, 511), 1, 1);
        3: set_dims(1, 1023, $urandom_range(1, 2));
        4: set_dims($urandom_range(5, 16), $urandom_range(1, 6), 65535);
        default: set_dims(1, 1, $urandom_range(1, 8));
      endcase
      send_random($urandom_range(10, 70), calm);
    end
    wait_idle();
    reg_write(RegUnused, 5);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
